// ===== rtl/mutual_exclusion_permission_node_top_defines.svh =====
// Assertion macros for the permission node checker.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef MUTUAL_EXCLUSION_PERMISSION_NODE_TOP_DEFINES_SVH
`define MUTUAL_EXCLUSION_PERMISSION_NODE_TOP_DEFINES_SVH

// Consequent in the same cycle
`define MEPN_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Consequent in the next cycle
`define MEPN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== rtl/mepn_pkg.sv =====
// Types, codes and helper functions for the permission node.
// Used by the controller, the datapath, the top level and the checker.
package mepn_pkg;

	localparam int MAX_NODES = 16;
	localparam int MAP_W     = 16;
	localparam int ID_W      = 4;
	localparam int CNT_W     = 5;
	localparam int CLK_W     = 32;
	localparam int NUM_W     = 5;
	localparam int ACT_CAP   = (MAX_NODES < MAP_W) ? MAX_NODES : MAP_W;

	localparam logic [CLK_W-1:0] CLK_MAX = '1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [2:0] OP_INIT     = 3'd0;
	localparam logic [2:0] OP_REQUEST  = 3'd1;
	localparam logic [2:0] OP_TRY      = 3'd2;
	localparam logic [2:0] OP_EXIT     = 3'd3;
	localparam logic [2:0] OP_REPLY_RX = 3'd4;
	localparam logic [2:0] OP_REQ_RX   = 3'd5;

	localparam logic [1:0] MSG_STATUS  = 2'd0;
	localparam logic [1:0] MSG_REQUEST = 2'd1;
	localparam logic [1:0] MSG_REPLY   = 2'd2;

	localparam logic [2:0] ADDR_W = 3'd3;

	typedef struct packed {
		logic [2:0]       opcode;
		logic [ID_W-1:0]  peer;
		logic [CLK_W-1:0] peer_clock;
	} mepn_cmd_t;

	typedef struct packed {
		logic [1:0]       msg_kind;
		logic [ID_W-1:0]  dest;
		logic [CLK_W-1:0] msg_clock;
		logic             granted;
		logic             in_section;
		logic             last;
	} mepn_result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WALK,
		ST_REPLY
	} mepn_state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic walk;
		logic reply;
	} mepn_ctl_t;

	typedef struct packed {
		logic walk_go;
		logic reply_go;
		logic walk_last;
	} mepn_sts_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
	endfunction

	function automatic logic [ID_W-1:0] low_idx(input logic [MAP_W-1:0] v);
		logic [ID_W-1:0] r;
		r = '0;
		for (int i = MAP_W - 1; i >= 0; i--) begin
			if (v[i]) r = ID_W'(i);
		end
		return r;
	endfunction

endpackage

// ===== rtl/mutual_exclusion_permission_node_top.sv =====
// Results are registered: the first is set up in the execute state (in the walk state for a
// peer walk), then one a cycle. Init, try enter and reply received use the execute state only;
// request received adds a reply state when it also sends a request; request access and exit add
// a walk state per peer messaged, one a cycle. busy falls in the cycle the last item shows.
// Reset: arst_n clears all protocol state, node_id to 0 and num_nodes to 16.
// Top level of the permission node; depends on mepn_pkg, mepn_ctrl and mepn_dp.
module mutual_exclusion_permission_node_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  mepn_pkg::mepn_cmd_t             cmd,
	output logic                            result_valid,
	output mepn_pkg::mepn_result_t          result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mepn_pkg::ADDR_W-1:0]     paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import mepn_pkg::*;

	logic [ID_W-1:0]  node_id_q;
	logic [NUM_W-1:0] num_nodes_q;
	logic             wr_en;
	mepn_ctl_t        ctl;
	mepn_sts_t        sts;

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = paddr[2] ? {{(32-NUM_W){1'b0}}, num_nodes_q}
	                         : {{(32-ID_W){1'b0}}, node_id_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q   <= '0;
			num_nodes_q <= NUM_W'(16);
		end else if (wr_en) begin
			if (paddr[2]) num_nodes_q <= pwdata[NUM_W-1:0];
			else node_id_q <= pwdata[ID_W-1:0];
		end
	end

	mepn_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	mepn_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.cmd          (cmd),
		.node_id      (node_id_q),
		.num_nodes    (num_nodes_q),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

// ===== rtl/mepn_ctrl.sv =====
// Controller state machine of the permission node.
// Depends on mepn_pkg; drives the datapath through mepn_ctl_t.
module mepn_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  mepn_pkg::mepn_sts_t sts,
	output mepn_pkg::mepn_ctl_t ctl,
	output logic               busy
);
	import mepn_pkg::*;

	mepn_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctl.exec = 1'b1;
				if (sts.walk_go) state_d = ST_WALK;
				else if (sts.reply_go) state_d = ST_REPLY;
				else state_d = ST_IDLE;
			end
			ST_WALK: begin
				ctl.walk = 1'b1;
				if (sts.walk_last) state_d = ST_IDLE;
			end
			ST_REPLY: begin
				ctl.reply = 1'b1;
				state_d   = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== rtl/mepn_dp.sv =====
// Datapath of the permission node: protocol state, peer walk and result register.
// Depends on mepn_pkg; commanded by mepn_ctrl.
module mepn_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mepn_pkg::mepn_ctl_t          ctl,
	output mepn_pkg::mepn_sts_t          sts,
	input  mepn_pkg::mepn_cmd_t          cmd,
	input  logic [mepn_pkg::ID_W-1:0]    node_id,
	input  logic [mepn_pkg::NUM_W-1:0]   num_nodes,
	output mepn_pkg::mepn_result_t       result,
	output logic                         result_valid
);
	import mepn_pkg::*;

	mepn_cmd_t        cmd_q;
	logic [MAP_W-1:0] ask_q, ask_d, defer_q, defer_d, pend_q, pend_d;
	logic [CLK_W-1:0] lt_q, lt_d, entry_q, entry_d;
	logic             want_q, want_d, inside_q, inside_d, wkind_q, wkind_d;
	logic [CNT_W-1:0] rexp_q, rexp_d, rrcv_q, rrcv_d;
	mepn_result_t     res_q, res_d;
	logic             vld_q, vld_d;

	logic [NUM_W-1:0] act_n;
	logic [MAP_W-1:0] nmask, self_bit, peer_bit, walk_bit;
	logic [CLK_W-1:0] lt_max, lt_bump, lt_inc;
	logic [ID_W-1:0]  walk_idx;
	logic             peer_ok, node_wins, grant, send_req, send_rep;

	assign act_n    = (num_nodes > NUM_W'(ACT_CAP)) ? NUM_W'(ACT_CAP) : num_nodes;
	assign nmask    = (act_n >= NUM_W'(MAP_W)) ? '1 : ((MAP_W'(1) << act_n) - 1'b1);
	assign self_bit = MAP_W'(1) << node_id;
	assign peer_bit = MAP_W'(1) << cmd_q.peer;
	assign peer_ok  = (NUM_W'(cmd_q.peer) < act_n) && (cmd_q.peer != node_id);
	assign lt_max   = (lt_q >= cmd_q.peer_clock) ? lt_q : cmd_q.peer_clock;
	assign lt_bump  = (lt_max == CLK_MAX) ? CLK_MAX : lt_max + 1'b1;
	assign lt_inc   = (lt_q == CLK_MAX) ? CLK_MAX : lt_q + 1'b1;
	assign node_wins = want_q && ((entry_q < cmd_q.peer_clock) ||
		((entry_q == cmd_q.peer_clock) && (node_id < cmd_q.peer)));
	assign walk_idx = low_idx(pend_q);
	assign walk_bit = MAP_W'(1) << walk_idx;

	always_comb begin
		ask_d    = ask_q;
		defer_d  = defer_q;
		pend_d   = pend_q;
		lt_d     = lt_q;
		entry_d  = entry_q;
		want_d   = want_q;
		inside_d = inside_q;
		wkind_d  = wkind_q;
		rexp_d   = rexp_q;
		rrcv_d   = rrcv_q;
		res_d    = res_q;
		vld_d    = 1'b0;
		grant    = 1'b0;
		send_req = 1'b0;
		send_rep = 1'b0;
		sts      = '0;
		if (ctl.exec) begin
			unique case (cmd_q.opcode)
				OP_INIT: begin
					ask_d    = (self_bit - 1'b1) & nmask;
					defer_d  = '0;
					lt_d     = '0;
					entry_d  = '0;
					want_d   = 1'b0;
					inside_d = 1'b0;
					rexp_d   = '0;
					rrcv_d   = '0;
				end
				OP_REQUEST: begin
					want_d      = 1'b1;
					rexp_d      = '0;
					rrcv_d      = '0;
					lt_d        = lt_inc;
					entry_d     = lt_inc;
					pend_d      = ask_q & nmask & ~self_bit;
					wkind_d     = 1'b0;
					sts.walk_go = |pend_d;
				end
				OP_TRY: begin
					if (want_q && (rrcv_q == rexp_q)) begin
						want_d   = 1'b0;
						inside_d = 1'b1;
						grant    = 1'b1;
					end
				end
				OP_EXIT: begin
					if (inside_q) begin
						inside_d    = 1'b0;
						pend_d      = defer_q & nmask & ~self_bit;
						wkind_d     = 1'b1;
						sts.walk_go = |pend_d;
					end
				end
				OP_REPLY_RX: begin
					if (peer_ok) begin
						rrcv_d = sat_inc(rrcv_q);
						lt_d   = lt_bump;
						ask_d  = ask_q & ~peer_bit;
					end
				end
				OP_REQ_RX: begin
					if (peer_ok) begin
						lt_d = lt_bump;
						if (inside_q || node_wins) begin
							defer_d = defer_q | peer_bit;
						end else begin
							ask_d    = ask_q | peer_bit;
							send_rep = 1'b1;
							if (want_q && !ask_q[cmd_q.peer]) begin
								rexp_d   = sat_inc(rexp_q);
								send_req = 1'b1;
							end
						end
					end
				end
				default: ;
			endcase
			sts.reply_go = send_req;
			vld_d        = !sts.walk_go;
			res_d.granted    = grant;
			res_d.in_section = inside_d;
			if (send_req) begin
				res_d.msg_kind  = MSG_REQUEST;
				res_d.dest      = cmd_q.peer;
				res_d.msg_clock = entry_q;
				res_d.last      = 1'b0;
			end else if (send_rep) begin
				res_d.msg_kind  = MSG_REPLY;
				res_d.dest      = cmd_q.peer;
				res_d.msg_clock = lt_d;
				res_d.last      = 1'b1;
			end else begin
				res_d.msg_kind  = MSG_STATUS;
				res_d.dest      = '0;
				res_d.msg_clock = lt_d;
				res_d.last      = 1'b1;
			end
		end else if (ctl.walk) begin
			pend_d           = pend_q & ~walk_bit;
			vld_d            = 1'b1;
			res_d.msg_kind   = wkind_q ? MSG_REPLY : MSG_REQUEST;
			res_d.dest       = walk_idx;
			res_d.msg_clock  = wkind_q ? lt_q : entry_q;
			res_d.granted    = 1'b0;
			res_d.in_section = inside_q;
			res_d.last       = (pend_d == '0);
			if (wkind_q) begin
				ask_d   = ask_q | walk_bit;
				defer_d = defer_q & ~walk_bit;
			end else begin
				rexp_d = sat_inc(rexp_q);
			end
		end else if (ctl.reply) begin
			vld_d            = 1'b1;
			res_d.msg_kind   = MSG_REPLY;
			res_d.dest       = cmd_q.peer;
			res_d.msg_clock  = lt_q;
			res_d.granted    = 1'b0;
			res_d.in_section = inside_q;
			res_d.last       = 1'b1;
		end
		sts.walk_last = ((pend_q & (pend_q - 1'b1)) == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ask_q    <= '0;
			defer_q  <= '0;
			pend_q   <= '0;
			lt_q     <= '0;
			entry_q  <= '0;
			want_q   <= 1'b0;
			inside_q <= 1'b0;
			wkind_q  <= 1'b0;
			rexp_q   <= '0;
			rrcv_q   <= '0;
			vld_q    <= 1'b0;
		end else begin
			ask_q    <= ask_d;
			defer_q  <= defer_d;
			pend_q   <= pend_d;
			lt_q     <= lt_d;
			entry_q  <= entry_d;
			want_q   <= want_d;
			inside_q <= inside_d;
			wkind_q  <= wkind_d;
			rexp_q   <= rexp_d;
			rrcv_q   <= rrcv_d;
			vld_q    <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (ctl.load) cmd_q <= cmd;
	end

	assign result       = res_q;
	assign result_valid = vld_q;

endmodule

// ===== rtl/mepn_checker.sv =====
// Port-level checker for the permission node, bound to the top level.
// Depends on mepn_pkg and mutual_exclusion_permission_node_top_defines.svh.
`include "mutual_exclusion_permission_node_top_defines.svh"

module mepn_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   result_valid,
	input mepn_pkg::mepn_result_t result
);
	import mepn_pkg::*;

	`MEPN_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after an item")
	`MEPN_ASSERT_NEXT(a_accept_quiet, start && !busy, !result_valid, "result too early")
	`MEPN_ASSERT_NEXT(a_burst, result_valid && !result.last, result_valid, "gap inside burst")
	`MEPN_ASSERT_SAME(a_last_idle, result_valid && result.last, !busy, "busy after last item")
	`MEPN_ASSERT_SAME(a_status_last, result_valid && result.msg_kind == MSG_STATUS, result.last, "status not last")

endmodule

bind mutual_exclusion_permission_node_top mepn_checker u_mepn_checker (.*);

// ===== tb/tb_mutual_exclusion_permission_node_top.sv =====
// Self-checking testbench for mutual_exclusion_permission_node_top: APB register set-up,
// directed protocol cases, then random request/reply/enter/exit rounds with idle gaps.
// Depends on mepn_pkg and the node RTL; a tracking class predicts every outgoing item.
module tb_mutual_exclusion_permission_node_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mepn_pkg::*;

	localparam int REG_NODE_ID   = 0;
	localparam int REG_NUM_NODES = 1;
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	class node_mirror;
		logic [3:0]   node_id;
		logic [4:0]   num_nodes;
		logic [15:0]  ask_map;
		logic [15:0]  defer_map;
		logic [31:0]  lamport;
		logic [31:0]  entry;
		bit           wanting;
		bit           in_cs;
		logic [4:0]   n_exp;
		logic [4:0]   n_rcv;
		mepn_result_t due[$];
		int           items;
		int           checked;
		int           grants;
		int           errors;

		function new();
			node_id = '0;
			num_nodes = 5'd16;
			ask_map = '0;
			defer_map = '0;
			lamport = '0;
			entry = '0;
			wanting = 1'b0;
			in_cs = 1'b0;
			n_exp = '0;
			n_rcv = '0;
			items = 0;
			checked = 0;
			grants = 0;
			errors = 0;
		endfunction

		function int unsigned active();
			return (num_nodes > 5'd16) ? 16 : int'(num_nodes);
		endfunction

		function void write_reg(int idx, logic [31:0] v);
			if (idx == REG_NODE_ID) node_id = v[3:0];
			else if (idx == REG_NUM_NODES) num_nodes = v[4:0];
		endfunction

		function logic [4:0] sat5(logic [4:0] v);
			return (v == '1) ? v : v + 5'd1;
		endfunction

		function void bump(logic [31:0] seen);
			logic [31:0] m;
			m = (lamport > seen) ? lamport : seen;
			lamport = (m == '1) ? m : m + 32'd1;
		endfunction

		function void push_msg(logic [1:0] kind, logic [3:0] dst, logic [31:0] clock,
				logic grant);
			mepn_result_t m;
			m.msg_kind = kind;
			m.dest = dst;
			m.msg_clock = clock;
			m.granted = grant;
			m.in_section = in_cs;
			m.last = 1'b0;
			due.push_back(m);
		endfunction

		function void note_command(mepn_cmd_t c);
			int unsigned n;
			logic [15:0] nmask;
			bit peer_ok;
			logic grant;
			int first;
			n = active();
			nmask = 16'((32'd1 << n) - 32'd1);
			peer_ok = (c.peer < n) && (c.peer != node_id);
			grant = 1'b0;
			first = due.size();
			items++;
			case (c.opcode)
				OP_INIT: begin
					ask_map = 16'((32'd1 << node_id) - 32'd1) & nmask;
					defer_map = '0;
					lamport = '0;
					entry = '0;
					wanting = 1'b0;
					in_cs = 1'b0;
					n_exp = '0;
					n_rcv = '0;
				end
				OP_REQUEST: begin
					wanting = 1'b1;
					n_exp = '0;
					n_rcv = '0;
					if (lamport != '1) lamport = lamport + 32'd1;
					entry = lamport;
					for (int i = 0; i < n; i++) begin
						if (i != node_id && ask_map[i]) begin
							n_exp = sat5(n_exp);
							push_msg(MSG_REQUEST, 4'(i), entry, 1'b0);
						end
					end
				end
				OP_TRY: begin
					if (wanting && n_rcv == n_exp) begin
						wanting = 1'b0;
						in_cs = 1'b1;
						grant = 1'b1;
						grants++;
					end
				end
				OP_EXIT: begin
					if (in_cs) begin
						in_cs = 1'b0;
						for (int i = 0; i < n; i++) begin
							if (i != node_id && defer_map[i]) begin
								push_msg(MSG_REPLY, 4'(i), lamport, 1'b0);
								ask_map[i] = 1'b1;
								defer_map[i] = 1'b0;
							end
						end
					end
				end
				OP_REPLY_RX: begin
					if (peer_ok) begin
						n_rcv = sat5(n_rcv);
						bump(c.peer_clock);
						ask_map[c.peer] = 1'b0;
					end
				end
				OP_REQ_RX: begin
					if (peer_ok) begin
						if (in_cs || (wanting && (entry < c.peer_clock ||
								(entry == c.peer_clock && node_id < c.peer)))) begin
							defer_map[c.peer] = 1'b1;
							bump(c.peer_clock);
						end else begin
							bump(c.peer_clock);
							if (wanting && !ask_map[c.peer]) begin
								ask_map[c.peer] = 1'b1;
								n_exp = sat5(n_exp);
								push_msg(MSG_REQUEST, c.peer, entry, 1'b0);
							end
							ask_map[c.peer] = 1'b1;
							push_msg(MSG_REPLY, c.peer, lamport, 1'b0);
						end
					end
				end
				default: ;
			endcase
			if (due.size() == first) push_msg(MSG_STATUS, 4'd0, lamport, grant);
			due[due.size() - 1].last = 1'b1;
		endfunction

		function string show(mepn_result_t m);
			return $sformatf("kind=%0d dest=%0d clock=%0h granted=%0b in_section=%0b last=%0b",
				m.msg_kind, m.dest, m.msg_clock, m.granted, m.in_section, m.last);
		endfunction

		function void report(string s);
			errors++;
			if (errors <= 40) $display("ERROR at %0t: %s", $time, s);
		endfunction

		function void check_message(mepn_result_t r);
			mepn_result_t e;
			checked++;
			if (due.size() == 0) begin
				report({"unexpected item ", show(r)});
				return;
			end
			e = due.pop_front();
			if (r.msg_kind !== e.msg_kind || r.dest !== e.dest || r.msg_clock !== e.msg_clock ||
					r.granted !== e.granted || r.in_section !== e.in_section ||
					r.last !== e.last)
				report({"got ", show(r), " / expected ", show(e)});
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	mepn_cmd_t               cmd;
	logic                    result_valid;
	mepn_result_t            result;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [ADDR_W-1:0]       paddr;
	logic [31:0]             pwdata;
	logic [31:0]             prdata;
	logic                    pready;

	node_mirror sb;
	bit         steady;
	int         settings_used;

	mutual_exclusion_permission_node_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid) sb.check_message(result);
	end

	function automatic mepn_cmd_t cmd_of(logic [2:0] op, logic [3:0] p, logic [31:0] c);
		mepn_cmd_t m;
		m.opcode = op;
		m.peer = p;
		m.peer_clock = c;
		return m;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [3:0] pick_peer(logic [15:0] map);
		int unsigned n;
		logic [3:0] cand[$];
		n = sb.active();
		for (int i = 0; i < n; i++)
			if (i != sb.node_id && map[i]) cand.push_back(4'(i));
		if (cand.size() == 0)
			for (int i = 0; i < n; i++)
				if (i != sb.node_id) cand.push_back(4'(i));
		if (cand.size() == 0) return 4'($urandom_range(0, 15));
		return cand[$urandom_range(0, cand.size() - 1)];
	endfunction

	function automatic logic [31:0] rnd_clock(logic [31:0] base);
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return base + 32'($urandom_range(0, 8));
		if (r < 62) return base - 32'($urandom_range(0, 3));
		if (r < 80) return $urandom;
		if (r < 84) return 32'hFFFF_FFFF - 32'($urandom_range(0, 2));
		return 32'($urandom_range(0, 16));
	endfunction

	task automatic issue(input mepn_cmd_t c);
		int g;
		g = gap_len();
		@(negedge clk);
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(negedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		sb.note_command(c);
	endtask

	task automatic apb_xfer(input bit wr, input int idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_W'(4 * idx);
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_register(input int idx, input logic [31:0] v);
		logic [31:0] rd;
		apb_xfer(1'b1, idx, v, rd);
		sb.write_reg(idx, v);
		apb_xfer(1'b0, idx, '0, rd);
		if (rd !== v) sb.report($sformatf("register %0d reads %0h after writing %0h", idx, rd, v));
	endtask

	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (24) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic configure(input logic [3:0] id, input logic [4:0] num);
		settle();
		set_register(REG_NODE_ID, 32'(id));
		set_register(REG_NUM_NODES, 32'(num));
		settings_used++;
	endtask

	task automatic protocol_round();
		int guard;
		int r;
		if ($urandom_range(0, 5) == 0)
			issue(cmd_of(OP_INIT, 4'($urandom_range(0, 15)), $urandom));
		issue(cmd_of(OP_REQUEST, 4'($urandom_range(0, 15)), $urandom));
		guard = 0;
		while (sb.n_rcv != sb.n_exp && guard < 40) begin
			guard++;
			r = $urandom_range(0, 9);
			if (r < 2)
				issue(cmd_of(OP_REQ_RX, pick_peer('1),
					sb.entry + 32'($urandom_range(0, 2)) - 32'd1));
			else if (r == 2)
				issue(cmd_of(OP_TRY, 4'($urandom_range(0, 15)), $urandom));
			else
				issue(cmd_of(OP_REPLY_RX, pick_peer(sb.ask_map), rnd_clock(sb.lamport)));
		end
		if ($urandom_range(0, 7) != 0)
			issue(cmd_of(OP_TRY, 4'($urandom_range(0, 15)), $urandom));
		if (sb.in_cs)
			repeat ($urandom_range(0, 3))
				issue(cmd_of(OP_REQ_RX, pick_peer('1), rnd_clock(sb.lamport)));
		if ($urandom_range(0, 9) != 0)
			issue(cmd_of(OP_EXIT, 4'($urandom_range(0, 15)), $urandom));
	endtask

	task automatic reply_flood();
		logic [3:0] p;
		p = pick_peer('1);
		repeat (33) issue(cmd_of(OP_REPLY_RX, p, rnd_clock(sb.lamport)));
		issue(cmd_of(OP_TRY, p, $urandom));
	endtask

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		int unsigned phase_ids[8];
		int unsigned phase_nums[8];
		int target;
		int r;
		phase_ids = '{0, 15, 9, 3, 7, 1, 6, 0};
		phase_nums = '{16, 16, 8, 1, 31, 2, 16, 0};
		sb = new();
		settings_used = 0;
		steady = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		configure(4'd5, 5'd8);
		issue(cmd_of(OP_INIT, 4'd0, 32'd0));
		issue(cmd_of(OP_TRY, 4'd0, 32'd0));
		issue(cmd_of(OP_EXIT, 4'd0, 32'd0));
		issue(cmd_of(OP_REPLY_RX, 4'd5, 32'd9));
		issue(cmd_of(OP_REQ_RX, 4'd9, 32'd2));
		issue(cmd_of(OP_REQ_RX, 4'd6, 32'd3));
		issue(cmd_of(OP_REQUEST, 4'd0, 32'd0));
		issue(cmd_of(OP_REQ_RX, 4'd3, sb.entry));
		issue(cmd_of(OP_REQ_RX, 4'd7, sb.entry));
		issue(cmd_of(OP_REQ_RX, 4'd1, sb.entry + 32'd5));
		issue(cmd_of(OP_TRY, 4'd0, 32'd0));
		for (int i = 0; i < 8; i++)
			if (sb.ask_map[i]) issue(cmd_of(OP_REPLY_RX, 4'(i), sb.lamport + 32'(i)));
		issue(cmd_of(OP_TRY, 4'd0, 32'd0));
		issue(cmd_of(OP_REQ_RX, 4'd4, 32'd1));
		issue(cmd_of(OP_EXIT, 4'd0, 32'd0));
		issue(cmd_of(OP_SPARE6, 4'd15, 32'hFFFF_FFFF));
		issue(cmd_of(OP_SPARE7, 4'd0, 32'd0));
		issue(cmd_of(OP_REQ_RX, 4'd2, 32'hFFFF_FFFF));
		issue(cmd_of(OP_REQUEST, 4'd0, 32'd0));
		issue(cmd_of(OP_REPLY_RX, 4'd15, 32'd7));
		configure(4'd12, 5'd8);
		issue(cmd_of(OP_INIT, 4'd0, 32'd0));

		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 7) begin
				phase_ids[ph] = $urandom_range(0, 15);
				phase_nums[ph] = $urandom_range(0, 31);
			end
			configure(4'(phase_ids[ph]), 5'(phase_nums[ph]));
			steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) != 0) issue(cmd_of(OP_INIT, 4'd0, $urandom));
			target = sb.items + 36;
			while (sb.items < target) begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					protocol_round();
				end else if (r < 97) begin
					repeat ($urandom_range(1, 3))
						issue(cmd_of(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
							rnd_clock(sb.lamport)));
				end else begin
					reply_flood();
				end
			end
		end

		settle();
		$display("Sent %0d commands across %0d register settings; %0d items checked, %0d grants.",
			sb.items, settings_used, sb.checked, sb.grants);
		if (sb.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("Verification failed");
		end
		$finish;
	end

endmodule
